[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

[rtl/core/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// tdp_pkg
// shared types and constants of the trial division primality test
// ----------------------------------------------------------------------------
package tdp_pkg;

   // default candidate width in bits, sign included
   localparam int DEF_VALUE_WIDTH = 32;

   // control of one serial remainder unit
   typedef struct packed {
      logic clear;
      logic shift;
      logic data_bit;
   } rem_ctl_type;

endpackage

[rtl/core/tdp_rem.sv]
// ----------------------------------------------------------------------------
// tdp_rem
// bit-serial remainder unit: one dividend bit per cycle while shift is set, msb first
// ----------------------------------------------------------------------------
module tdp_rem #(
   parameter int DIV_WIDTH = 17
) (
   input  logic                    clock,
   input  tdp_pkg::rem_ctl_type    ctl,
   input  logic [DIV_WIDTH-1:0]    divisor,
   output logic [DIV_WIDTH-1:0]    remainder
);

   logic [DIV_WIDTH-1:0] rem_ff;
   logic [DIV_WIDTH-1:0] rem_in;
   logic [DIV_WIDTH:0]   trial;
   logic [DIV_WIDTH:0]   divisor_ext;

   assign trial       = {rem_ff, ctl.data_bit};
   assign divisor_ext = {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      if (ctl.clear) begin
         rem_in = '0;
      end else if (ctl.shift) begin
         // restoring step: partial remainder stays below the divisor
         if (trial >= divisor_ext) begin
            rem_in = DIV_WIDTH'(trial - divisor_ext);
         end else begin
            rem_in = DIV_WIDTH'(trial);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

[rtl/core/trial_division_primality_test.sv]
// ----------------------------------------------------------------------------
// trial_division_primality_test
// primality test of a signed candidate by 6k +/- 1 trial division
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_ready / req_candidate) takes one signed item;
//   rsp channel (rsp_valid / rsp_ready / rsp_is_prime) returns one item each.
//   req_ready is high while the sequencer is idle; one item is worked at a time.
// sequence:
//   negative, 0..3: straight to the finish state and the output register.
//   otherwise one pass per divisor pair, first pair (2,3) then (5,7), (11,13)..
//   a pass is a bound check, VALUE_WIDTH-1 serial remainder shifts through the
//   two bit-serial remainder units, and an evaluation; pairs ~ sqrt(n) / 6.
//   even candidates and multiples of 3 end after the first pass.
// stalls:
//   the result sits in an output register; the next item is taken while it
//   waits, and a later result waits in the finish state until the slot frees.
// reset:
//   synchronous, clears the sequencer and the output valid; no other state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trial_division_primality_test #(
   parameter int VALUE_WIDTH = tdp_pkg::DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_candidate,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_prime
);

   // magnitude bits of a non-negative candidate
   localparam int NW = VALUE_WIDTH - 1;
   // divisor width: covers sqrt(2^NW) plus one wheel step
   localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
   // running square and its increment
   localparam int SW = 2 * DW;
   // serial shift counter
   localparam int CW = (NW > 1) ? $clog2(NW) : 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] shreg_ff, shreg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] da_ff, da_in;
   logic [DW-1:0] db_ff, db_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic [SW-1:0] inc_ff, inc_in;
   logic          first_ff, first_in;
   logic          verdict_ff, verdict_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_is_prime_ff, rsp_is_prime_in;

   tdp_pkg::rem_ctl_type rem_ctl;
   logic [DW-1:0]        rem_a;
   logic [DW-1:0]        rem_b;
   logic [NW-1:0]        cand_mag;
   logic                 out_free;

   assign cand_mag  = req_candidate[NW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // two remainder units share the dividend bit stream
   tdp_rem #(.DIV_WIDTH(DW)) u_rem_a (
      .clock     (clock),
      .ctl       (rem_ctl),
      .divisor   (da_ff),
      .remainder (rem_a)
   );

   tdp_rem #(.DIV_WIDTH(DW)) u_rem_b (
      .clock     (clock),
      .ctl       (rem_ctl),
      .divisor   (db_ff),
      .remainder (rem_b)
   );

   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      shreg_in        = shreg_ff;
      cnt_in          = cnt_ff;
      da_in           = da_ff;
      db_in           = db_ff;
      sq_in           = sq_ff;
      inc_in          = inc_ff;
      first_in        = first_ff;
      verdict_in      = verdict_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      // output slot drains when taken
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rem_ctl          = '0;
      rem_ctl.data_bit = shreg_ff[NW-1];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_candidate[VALUE_WIDTH-1]) begin
                  // negative: never prime
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else if (cand_mag <= NW'(1)) begin
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else if (cand_mag <= NW'(3)) begin
                  verdict_in = 1'b1;
                  state_in   = ST_FINISH;
               end else begin
                  // first pass tries 2 and 3, then the wheel starts at 5
                  n_in     = cand_mag;
                  da_in    = DW'(2);
                  db_in    = DW'(3);
                  sq_in    = SW'(4);
                  inc_in   = '0;
                  first_in = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sq_ff > SW'(n_ff)) begin
               // no divisor up to the square root
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               shreg_in      = n_ff;
               cnt_in        = '0;
               rem_ctl.clear = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_ctl.shift = 1'b1;
            shreg_in      = shreg_ff << 1;
            cnt_in        = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rem_a == '0 || rem_b == '0) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               if (first_ff) begin
                  da_in    = DW'(5);
                  db_in    = DW'(7);
                  sq_in    = SW'(25);
                  // (d+6)^2 - d^2 = 12d + 36, at d = 5
                  inc_in   = SW'(96);
                  first_in = 1'b0;
               end else begin
                  da_in  = da_ff + DW'(6);
                  db_in  = db_ff + DW'(6);
                  sq_in  = sq_ff + inc_ff;
                  inc_in = inc_ff + SW'(72);
               end
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      shreg_ff        <= shreg_in;
      cnt_ff          <= cnt_in;
      da_ff           <= da_in;
      db_ff           <= db_in;
      sq_ff           <= sq_in;
      inc_ff          <= inc_in;
      first_ff        <= first_in;
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // an accepted item always leaves idle
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)
   // a new result is only loaded from the finish state
   `ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   // wheel divisors are odd once the first pass is done
   `ASSERT_IMPLIES(a_wheel_odd, clock, reset, state_ff == ST_CHECK && !first_ff, da_ff[0] && db_ff[0])
   // the serial pass never runs past the dividend width
   `ASSERT_IMPLIES(a_div_count, clock, reset, state_ff == ST_DIV, cnt_ff <= CW'(NW - 1))

endmodule
